### rtl/uqp_pkg.sv
`default_nettype none

package uqp_pkg;

  // Raw characters with a role in the query string
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharSpace = 8'h20;

  // Most results one input byte can cause
  localparam int unsigned MaxResults = 4;
  localparam int unsigned SlotIdxW   = 2;

  // Escape scanner state
  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX  = 3'b100
  } esc_e;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_value;
    logic       arg_end;
  } res_t;

  // All results of one input byte, slot 0 first
  typedef struct packed {
    res_t [MaxResults-1:0] slot;
    logic [SlotIdxW-1:0]   last_idx;
  } bundle_t;

  // Hex digit lookup
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### rtl/uqp_front.sv
`default_nettype none

module uqp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic             end_of_string_i,
  output logic                  push_o,
  output uqp_pkg::bundle_t      bundle_o,
  input  wire logic             full_i
);

  uqp_pkg::esc_e esc_q, esc_d;
  logic [7:0]    fh_q, fh_d;
  logic          vp_q, vp_d;
  logic          st_q, st_d;
  logic [2:0]    n;
  logic          accept;
  uqp_pkg::hex_t hv, hv_held;

  function automatic uqp_pkg::res_t mk(input logic [7:0] b, input logic has,
                                       input logic fin, input logic vp);
    uqp_pkg::res_t r;
    r.out_byte = has ? b : 8'd0;
    r.has_byte = has;
    r.in_value = has & vp;
    r.arg_end  = fin;
    return r;
  endfunction

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign hv         = uqp_pkg::hex_decode(in_byte_i);
  assign hv_held    = uqp_pkg::hex_decode(fh_q);

  // Classify the byte and collect its results in order
  always_comb begin
    esc_d         = esc_q;
    fh_d          = fh_q;
    vp_d          = vp_q;
    st_d          = st_q;
    n             = 3'd0;
    bundle_o.slot = '0;
    if (esc_q == uqp_pkg::ESC_PCT && hv.ok) begin
      fh_d  = in_byte_i;
      esc_d = uqp_pkg::ESC_HEX;
      st_d  = 1'b1;
    end else if (esc_q == uqp_pkg::ESC_HEX && hv.ok) begin
      bundle_o.slot[n[1:0]] = mk({hv_held.nib, hv.nib}, 1'b1, 1'b0, vp_q);
      n     = n + 3'd1;
      esc_d = uqp_pkg::ESC_IDLE;
      fh_d  = 8'd0;
    end else begin
      // flush a broken escape literally, then rescan the byte
      if (esc_q != uqp_pkg::ESC_IDLE) begin
        bundle_o.slot[n[1:0]] = mk(uqp_pkg::CharPct, 1'b1, 1'b0, vp_q);
        n = n + 3'd1;
      end
      if (esc_q == uqp_pkg::ESC_HEX) begin
        bundle_o.slot[n[1:0]] = mk(fh_q, 1'b1, 1'b0, vp_q);
        n = n + 3'd1;
      end
      esc_d = uqp_pkg::ESC_IDLE;
      fh_d  = 8'd0;
      if (in_byte_i == uqp_pkg::CharAmp) begin
        if (st_q) begin
          bundle_o.slot[n[1:0]] = mk(8'd0, 1'b0, 1'b1, 1'b0);
          n = n + 3'd1;
        end
        st_d = 1'b0;
        vp_d = 1'b0;
      end else begin
        st_d = 1'b1;
        if (in_byte_i == uqp_pkg::CharEq && !vp_q) begin
          vp_d = 1'b1;
        end else if (in_byte_i == uqp_pkg::CharPlus) begin
          bundle_o.slot[n[1:0]] = mk(uqp_pkg::CharSpace, 1'b1, 1'b0, vp_q);
          n = n + 3'd1;
        end else if (in_byte_i == uqp_pkg::CharPct) begin
          esc_d = uqp_pkg::ESC_PCT;
        end else begin
          bundle_o.slot[n[1:0]] = mk(in_byte_i, 1'b1, 1'b0, vp_q);
          n = n + 3'd1;
        end
      end
    end
    // close the string: flush an unfinished escape, end the open entry
    if (end_of_string_i) begin
      if (esc_d != uqp_pkg::ESC_IDLE) begin
        bundle_o.slot[n[1:0]] = mk(uqp_pkg::CharPct, 1'b1, 1'b0, vp_q);
        n = n + 3'd1;
      end
      if (esc_d == uqp_pkg::ESC_HEX) begin
        bundle_o.slot[n[1:0]] = mk(fh_d, 1'b1, 1'b0, vp_q);
        n = n + 3'd1;
      end
      if (st_d) begin
        bundle_o.slot[n[1:0]] = mk(8'd0, 1'b0, 1'b1, 1'b0);
        n = n + 3'd1;
      end
      esc_d = uqp_pkg::ESC_IDLE;
      fh_d  = 8'd0;
      st_d  = 1'b0;
      vp_d  = 1'b0;
    end
    bundle_o.last_idx = uqp_pkg::SlotIdxW'(n - 3'd1);
  end

  assign push_o = accept & (n != 3'd0);

  // Advance scanner state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= uqp_pkg::ESC_IDLE;
      fh_q  <= 8'd0;
      vp_q  <= 1'b0;
      st_q  <= 1'b0;
    end else if (accept) begin
      esc_q <= esc_d;
      fh_q  <= fh_d;
      vp_q  <= vp_d;
      st_q  <= st_d;
    end
  end

endmodule

`default_nettype wire

### rtl/uqp_queue.sv
`default_nettype none

module uqp_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire uqp_pkg::bundle_t  wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output uqp_pkg::bundle_t       rdata_o,
  output logic                   empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  uqp_pkg::bundle_t mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  // Store pushed bundles
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/uqp_back.sv
`default_nettype none

module uqp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire uqp_pkg::bundle_t  bundle_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output uqp_pkg::res_t          res_o,
  output logic                   out_last_o
);

  logic [uqp_pkg::SlotIdxW-1:0] sub_q;
  logic                         fire;

  assign out_valid_o = ~empty_i;
  assign res_o       = bundle_i.slot[sub_q];
  assign out_last_o  = (sub_q == bundle_i.last_idx);
  assign fire        = out_valid_o & out_ready_i;
  assign pop_o       = fire & out_last_o;

  // Step through the slots of the head bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else if (fire) begin
      sub_q <= out_last_o ? '0 : sub_q + uqp_pkg::SlotIdxW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/urlencoded_query_parser.sv
`default_nettype none

// Streaming decoder for a form-urlencoded query string. One raw byte enters per
// cycle on the slave side, whose tready falls only when the queue is full (tlast
// marks the final byte of the string); decoded key and value bytes and
// end-of-argument records leave on the master side, one result per cycle while
// the sink is ready, with tlast on the final result of each input byte. An input
// byte causes zero to four results; the front end classifies a byte and hands
// its results as one bundle to a QueueDepth-entry queue, and the back end drains
// a bundle at one result per cycle while the sink is ready. Input takes one byte
// per cycle while bytes cause at most one result each and the sink stays ready.
module urlencoded_query_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // end_of_string
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]       m_axis_tuser_o,   // [0] has_byte, [1] in_value, [2] arg_end
  output logic             m_axis_tlast_o    // last
);

  uqp_pkg::bundle_t push_bundle, head_bundle;
  uqp_pkg::res_t    res;
  logic             push, full, pop, empty;

  uqp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .in_byte_i       (s_axis_tdata_i),
    .end_of_string_i (s_axis_tlast_i),
    .push_o          (push),
    .bundle_o        (push_bundle),
    .full_i          (full)
  );

  uqp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_bundle),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_bundle),
    .empty_o (empty)
  );

  uqp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bundle_i    (head_bundle),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack the result item onto the master side
  assign m_axis_tdata_o = res.out_byte;
  assign m_axis_tuser_o = {res.arg_end, res.in_value, res.has_byte};

endmodule

`default_nettype wire

### rtl/uqp_checker.sv
`default_nettype none

module uqp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [2:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // An end-of-argument record carries no byte and ends its input's results
  a_argend_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> !m_axis_tuser_o[0] && m_axis_tlast_o)
    else $error("arg_end result carries a byte or is not last");

  // A result without a byte shows a zero byte
  a_nobyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'd0)
    else $error("byte field nonzero without has_byte");

  // Only byte results are tagged as value
  a_value_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("in_value set on a result without a byte");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

endmodule

bind urlencoded_query_parser uqp_checker u_uqp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

### tb/tb_urlencoded_query_parser.sv
`timescale 1ns / 100ps

module tb_urlencoded_query_parser;

  // Escape scanner positions of the predictor
  localparam logic [1:0] EscNone = 2'd0;
  localparam logic [1:0] EscPct  = 2'd1;
  localparam logic [1:0] EscHex  = 2'd2;

  localparam logic [4:0] NotHex     = 5'h10;
  localparam int         CycleLimit = 200000;
  localparam int         DrainWait  = 16;
  localparam int         HoldStart  = 350;
  localparam int         HoldCycles = 200;

  // One decoded result as the block should present it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_value;
    logic       arg_end;
    logic       last;
  } decoded_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  logic [8:0] raw_q[$];       // {end_of_string, byte} waiting to be sent
  decoded_t   decoded_q[$];   // results the block still owes

  // Predictor state
  logic [1:0] esc_pos;
  logic [7:0] held_digit;
  logic       in_val;
  logic       entry_open;

  int   n_items     = 0;
  int   taken_cnt   = 0;
  int   err_cnt     = 0;
  int   cyc         = 0;
  int   hold_cyc    = 0;
  int   hold_phase  = 0;
  logic in_taken    = 1'b0;

  urlencoded_query_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Hex digit value, or NotHex
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, c[3:0]};
    end
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      return {1'b0, c[3:0]} + 5'd9;
    end
    return NotHex;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) begin
      return 8'h30 + nib;
    end
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic owe_result(input logic [7:0] b, input logic has, input logic aend);
    decoded_t r;
    r.out_byte = has ? b : 8'h00;
    r.has_byte = has;
    r.in_value = has ? in_val : 1'b0;
    r.arg_end  = aend;
    r.last     = 1'b0;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  // Emit a pending escape literally
  task automatic release_escape();
    if (esc_pos != EscNone) begin
      owe_result(uqp_pkg::CharPct, 1'b1, 1'b0);
    end
    if (esc_pos == EscHex) begin
      owe_result(held_digit, 1'b1, 1'b0);
    end
    esc_pos    = EscNone;
    held_digit = 8'h00;
  endtask

  // Ordinary byte outside an escape
  task automatic decode_plain(input logic [7:0] b);
    if (b == uqp_pkg::CharAmp) begin
      if (entry_open) begin
        owe_result(8'h00, 1'b0, 1'b1);
      end
      entry_open = 1'b0;
      in_val     = 1'b0;
    end else begin
      entry_open = 1'b1;
      if (b == uqp_pkg::CharEq && !in_val) begin
        in_val = 1'b1;
      end else if (b == uqp_pkg::CharPlus) begin
        owe_result(uqp_pkg::CharSpace, 1'b1, 1'b0);
      end else if (b == uqp_pkg::CharPct) begin
        esc_pos = EscPct;
      end else begin
        owe_result(b, 1'b1, 1'b0);
      end
    end
  endtask

  // Work out the results of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic eos);
    logic [4:0] nib;
    logic [4:0] hi_nib;
    int         first;
    nib   = nibble_of(b);
    first = decoded_q.size();
    if (esc_pos == EscPct && nib != NotHex) begin
      held_digit = b;
      esc_pos    = EscHex;
      entry_open = 1'b1;
    end else if (esc_pos == EscHex && nib != NotHex) begin
      hi_nib = nibble_of(held_digit);
      owe_result({hi_nib[3:0], nib[3:0]}, 1'b1, 1'b0);
      esc_pos    = EscNone;
      held_digit = 8'h00;
    end else begin
      release_escape();
      decode_plain(b);
    end
    if (eos) begin
      release_escape();
      if (entry_open) begin
        owe_result(8'h00, 1'b0, 1'b1);
      end
      entry_open = 1'b0;
      in_val     = 1'b0;
    end
    // Mark the final result of this byte
    if (decoded_q.size() > first) begin
      decoded_q[decoded_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic push_raw(input logic [7:0] b);
    raw_q.insert(raw_q.size(), {1'b0, b});
  endtask

  task automatic close_string();
    raw_q[raw_q.size() - 1][8] = 1'b1;
  endtask

  task automatic push_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      push_raw(s[i]);
    end
    if (close) begin
      close_string();
    end
  endtask

  // One piece of key or value content, mostly well formed
  task automatic push_content();
    string pool;
    int    r;
    pool = "aZ09.-_~xQ";
    r    = $urandom_range(0, 99);
    if (r < 45) begin
      push_raw(pool[$urandom_range(0, pool.len() - 1)]);
    end else if (r < 55) begin
      push_raw(uqp_pkg::CharPlus);
    end else if (r < 70) begin
      push_raw(uqp_pkg::CharPct);
      push_raw(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      push_raw(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end else if (r < 78) begin
      // broken escape: a non-hex byte after '%' or after its first digit
      push_raw(uqp_pkg::CharPct);
      if ($urandom_range(0, 1)) begin
        push_raw(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      end
      case ($urandom_range(0, 4))
        0: push_raw(uqp_pkg::CharAmp);
        1: push_raw(uqp_pkg::CharEq);
        2: push_raw(uqp_pkg::CharPlus);
        3: push_raw(uqp_pkg::CharPct);
        default: push_raw("g");
      endcase
    end else if (r < 85) begin
      push_raw(uqp_pkg::CharEq);
    end else begin
      push_raw(8'($urandom_range(0, 255)));
    end
  endtask

  // One query string: key/value arguments, or now and then plain noise
  task automatic push_query();
    int start;
    start = raw_q.size();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 5))
          0: push_raw(uqp_pkg::CharPct);
          1: push_raw(uqp_pkg::CharAmp);
          2: push_raw(uqp_pkg::CharEq);
          3: push_raw(uqp_pkg::CharPlus);
          4: push_raw(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          default: push_raw(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        push_raw(uqp_pkg::CharAmp);
      end
      for (int a = $urandom_range(1, 4); a > 0; a--) begin
        repeat ($urandom_range(0, 5)) push_content();
        if ($urandom_range(0, 3) != 0) begin
          push_raw(uqp_pkg::CharEq);
          repeat ($urandom_range(0, 6)) push_content();
        end
        if (a > 1) begin
          push_raw(uqp_pkg::CharAmp);
          if ($urandom_range(0, 5) == 0) begin
            push_raw(uqp_pkg::CharAmp);
          end
        end
      end
    end
    if (raw_q.size() == start) begin
      push_raw("k");
    end
    close_string();
  endtask

  // Sender: predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) begin
      decode_byte(s_tdata, s_tlast);
      taken_cnt <= taken_cnt + 1;
      in_taken = 1'b1;
    end
  end

  // Sender: offer the next item or idle
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (raw_q.size() > 0 &&
          ((taken_cnt >= 150 && taken_cnt < 250) || $urandom_range(0, 99) >= 26)) begin
        {s_tlast, s_tdata} <= raw_q.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once the run is under way
  always @(posedge clk_i) begin
    if (hold_phase == 0 && taken_cnt >= HoldStart) begin
      hold_phase <= 1;
    end else if (hold_phase == 1) begin
      hold_cyc <= hold_cyc + 1;
      if (hold_cyc + 1 >= HoldCycles) begin
        hold_phase <= 2;
      end
    end
  end

  // Receiver: stall at random, never during the calm stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_phase == 1) begin
        m_tready <= 1'b0;
      end else if (taken_cnt >= 150 && taken_cnt < 250) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Compare each accepted result with the oldest one owed
  always @(posedge clk_i) begin
    decoded_t want;
    decoded_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{out_byte: m_tdata, has_byte: m_tuser[0], in_value: m_tuser[1],
              arg_end: m_tuser[2], last: m_tlast};
      if (decoded_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("[%0t] unexpected result: byte %02h has %b val %b end %b last %b",
                   $realtime, got.out_byte, got.has_byte, got.in_value, got.arg_end,
                   got.last);
        end
      end else begin
        want = decoded_q.pop_front();
        if (got != want) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("[%0t] mismatch: expected byte %02h has %b val %b end %b last %b",
                     $realtime, want.out_byte, want.has_byte, want.in_value,
                     want.arg_end, want.last);
            $display("[%0t]           actual byte %02h has %b val %b end %b last %b",
                     $realtime, got.out_byte, got.has_byte, got.in_value, got.arg_end,
                     got.last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    esc_pos    = EscNone;
    held_digit = 8'h00;
    in_val     = 1'b0;
    entry_open = 1'b0;

    // Directed: dropped leading entry, bare '=', escape finished by the last byte
    push_text("&=%4a", 1'b1);
    // Byte extremes, '+', invalid escape, empty entries, escape cut by end of string
    push_raw(8'h00);
    push_text("+%G&&", 1'b0);
    push_raw(8'hFF);
    push_text("=%4", 1'b1);
    // Held digit then a non-hex byte at the end: four results on one byte
    push_text("k%4x", 1'b1);
    // Escape cut by '=', then a lone '%' at the end
    push_text("%F=%", 1'b1);
    // Lone separator string and a bare '=' string
    push_text("&", 1'b1);
    push_text("=", 1'b1);

    // Random queries
    while (raw_q.size() < 525) begin
      push_query();
    end
    n_items = raw_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all sent, nothing owed, then let the pipeline settle
    while (taken_cnt < n_items || decoded_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainWait) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/uqp_pkg.sv
rtl/uqp_front.sv
rtl/uqp_queue.sv
rtl/uqp_back.sv
rtl/urlencoded_query_parser.sv
rtl/uqp_checker.sv
tb/tb_urlencoded_query_parser.sv
